/* hw/rtl/scfp_pkg.sv */
// Shared constants and types for the serial command frame parser.
`timescale 1ns / 1ps

package scfp_pkg;

  // Axes carried in every load frame, and axes actually committed.
  localparam int FRAME_AXES = 4;
  localparam int AXIS_COUNT = 4;

  localparam int PAYLOAD_LEN  = 32;
  localparam int PAYLOAD_BITS = PAYLOAD_LEN * 8;
  localparam int WORD_BITS    = 32;

  localparam logic [5:0] POS_HUNT    = 6'd0;
  localparam logic [5:0] POS_COMMAND = 6'd1;
  localparam logic [5:0] POS_FIRST   = 6'd2;
  localparam logic [5:0] XOR_POS     = 6'd34;

  localparam logic [7:0] HDR_BYTE = 8'hEC;
  localparam logic [7:0] CMD_STOP = 8'hFF;
  localparam logic [7:0] CMD_RUN  = 8'h00;
  localparam logic [7:0] CMD_ECHO = 8'h01;
  localparam logic [7:0] CMD_LOAD = 8'h55;

  localparam logic [7:0] RPL_RECV = 8'h00;
  localparam logic [7:0] RPL_DONE = 8'hFF;
  localparam logic [7:0] RPL_ERR  = 8'hEE;
  localparam logic [7:0] RPL_ECHO = 8'hEC;

  typedef struct packed {
    logic shift;   // push one payload byte
    logic commit;  // copy staged payload to the action registers
  } action_ctrl_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] code;
  } reply_t;

endpackage

/* hw/rtl/scfp_parser.sv */
// Frame parser: byte position, command, running XOR and mode flag.
`timescale 1ns / 1ps

module scfp_parser
  import scfp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         step,
  input  logic [7:0]   rx_byte,
  output action_ctrl_t ctrl,
  output reply_t       reply,
  output logic         run_mode
);

  logic [5:0] byte_position, byte_position_next;
  logic [7:0] command_code, command_code_next;
  logic [7:0] running_parity, running_parity_next;
  logic       mode_flag, mode_flag_next;

  always_comb begin
    byte_position_next  = byte_position;
    command_code_next   = command_code;
    running_parity_next = running_parity;
    mode_flag_next      = mode_flag;
    ctrl                = '0;
    reply               = '0;
    if (step) begin
      if (byte_position == POS_HUNT) begin
        if (rx_byte == HDR_BYTE) begin
          byte_position_next  = POS_COMMAND;
          running_parity_next = '0;
        end
      end else if (byte_position == POS_COMMAND) begin
        command_code_next  = rx_byte;
        byte_position_next = POS_FIRST;
      end else if (command_code == CMD_LOAD) begin
        if (byte_position < XOR_POS) begin
          ctrl.shift          = 1'b1;
          running_parity_next = running_parity ^ rx_byte;
          byte_position_next  = byte_position + 6'd1;
        end else begin
          reply.valid = 1'b1;
          if (running_parity == rx_byte) begin
            ctrl.commit = 1'b1;
            reply.code  = RPL_RECV;
          end else begin
            reply.code  = RPL_ERR;
          end
          byte_position_next = POS_HUNT;
        end
      end else begin
        // Three-byte frames end here whatever the command was.
        reply.valid = 1'b1;
        if (command_code inside {CMD_STOP, CMD_RUN}) begin
          if (rx_byte == command_code) begin
            mode_flag_next = (command_code == CMD_RUN);
            reply.code     = RPL_DONE;
          end else begin
            reply.code     = RPL_ERR;
          end
        end else if (command_code == CMD_ECHO) begin
          reply.code = RPL_ECHO;
        end else begin
          reply.code = RPL_ERR;
        end
        byte_position_next = POS_HUNT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= POS_HUNT;
      command_code   <= '0;
      running_parity <= '0;
      mode_flag      <= 1'b0;
    end else begin
      byte_position  <= byte_position_next;
      command_code   <= command_code_next;
      running_parity <= running_parity_next;
      mode_flag      <= mode_flag_next;
    end
  end

  assign run_mode = mode_flag;

endmodule

/* hw/rtl/scfp_action_regs.sv */
// Payload staging shift line and committed interval / step registers.
`timescale 1ns / 1ps

module scfp_action_regs
  import scfp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  action_ctrl_t         ctrl,
  input  logic [7:0]           rx_byte,
  output logic [WORD_BITS-1:0] intervals [FRAME_AXES],
  output logic [WORD_BITS-1:0] steps     [FRAME_AXES]
);

  // First payload byte ends up in the top byte after 32 shifts.
  logic [PAYLOAD_BITS-1:0] staging;

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      staging <= {staging[PAYLOAD_BITS-9:0], rx_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < FRAME_AXES; k++) begin
        intervals[k] <= '0;
        steps[k]     <= '0;
      end
    end else if (ctrl.commit) begin
      for (int k = 0; k < AXIS_COUNT; k++) begin
        intervals[k] <= staging[PAYLOAD_BITS-1-WORD_BITS*k -: WORD_BITS];
        steps[k]     <= staging[PAYLOAD_BITS/2-1-WORD_BITS*k -: WORD_BITS];
      end
    end
  end

endmodule

/* hw/rtl/serial_command_frame_parser_top.sv */
// Top level of the serial command frame parser.
`timescale 1ns / 1ps
//
// Parses command frames from a stream of received UART bytes, one byte per
// slave transaction. Header 0xEC opens a frame; stop/run/echo frames are three
// bytes, load frames carry 32 payload bytes plus an XOR check byte.
// Every input byte produces exactly one master transaction: m_tuser flags
// whether a reply byte is present, m_tdata carries the reply code, the run
// mode and the committed intervals and step counts as they stand after that
// byte.
// Latency: two register stages (input register, then result register);
// m_tvalid rises when the result register loads the accepted byte.
// Throughput: one byte per cycle unless the receiver stalls; all parsing is a
// single combinational pass between the input register and the result register.
// Reset (rst, synchronous) empties both registers, returns the parser to
// header hunt, stops the mode and clears all committed values.
// When the receiver stalls, the result register holds and the input register
// fills; s_tready then drops until the result is taken. Parser state only
// advances when a result is loaded, so the reported values always match the
// byte being delivered.

module serial_command_frame_parser_top
  import scfp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // [7:0] rx_byte
  output logic         m_tvalid,
  input  logic         m_tready,
  // [7:0] reply_byte, [8] run_mode, [40:9] interval_a, [72:41] interval_b,
  // [104:73] interval_c, [136:105] interval_d, [168:137] steps_a,
  // [200:169] steps_b, [232:201] steps_c, [264:233] steps_d, [271:265] zero
  output logic [271:0] m_tdata,
  output logic         m_tuser    // [0] reply_valid
);

  logic         in_valid;
  logic [7:0]   in_byte;
  logic         out_ready;
  logic         step;
  action_ctrl_t ctrl;
  reply_t       reply;
  reply_t       reply_q;
  logic         run_mode;
  logic [WORD_BITS-1:0] intervals [FRAME_AXES];
  logic [WORD_BITS-1:0] steps     [FRAME_AXES];

  assign out_ready = !m_tvalid || m_tready;
  assign step      = in_valid && out_ready;
  assign s_tready  = !in_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  scfp_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .rx_byte  (in_byte),
    .ctrl     (ctrl),
    .reply    (reply),
    .run_mode (run_mode)
  );

  scfp_action_regs u_action_regs (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .rx_byte   (in_byte),
    .intervals (intervals),
    .steps     (steps)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_ready) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      reply_q <= reply;
    end
  end

  assign m_tuser = reply_q.valid;
  assign m_tdata = {7'd0,
                    steps[3], steps[2], steps[1], steps[0],
                    intervals[3], intervals[2], intervals[1], intervals[0],
                    run_mode, reply_q.code};

endmodule
